/* hdl/pol_pkg.sv */
// ----------------------------------------------------------------------------
// pol_pkg: shared types and codes of the positional ordered list
// Command codes, status codes, controller states and the control word that
// the list controller broadcasts to every cell of the row.
// ----------------------------------------------------------------------------
package pol_pkg;

	localparam int POL_CAPACITY = 32;
	localparam int CTL_W = 7;

	typedef enum logic [2:0] {
		CMD_INS_FRONT = 3'd0,
		CMD_INS_BACK  = 3'd1,
		CMD_INS_AT    = 3'd2,
		CMD_DEL_FRONT = 3'd3,
		CMD_DEL_BACK  = 3'd4,
		CMD_DEL_AT    = 3'd5,
		CMD_DUMP      = 3'd6
	} cmd_t;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_EMPTY = 2'd1;
	localparam logic [1:0] STS_NOPOS = 2'd2;
	localparam logic [1:0] STS_FULL  = 2'd3;

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} state_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INS,
		CELL_DEL,
		CELL_ROT
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [CTL_W-1:0] idx;
		logic [CTL_W-1:0] len;
	} cell_ctl_t;

endpackage

/* hdl/pol_cell.sv */
// ----------------------------------------------------------------------------
// pol_cell: one storage cell of the list row
// Holds one element and, on each command, keeps it, takes the inserted value,
// takes the neighbor below or above, or takes the head element during a dump.
// ----------------------------------------------------------------------------
module pol_cell #(
	parameter int INDEX = 0
) (
	input  logic                clk,
	input  pol_pkg::cell_ctl_t  ctl,
	input  logic [31:0]         value_in,
	input  logic [31:0]         left_in,
	input  logic [31:0]         right_in,
	input  logic [31:0]         head_in,
	output logic [31:0]         data
);
	import pol_pkg::*;

	localparam logic [CTL_W-1:0] J = CTL_W'(INDEX);

	logic [31:0]      data_q;
	logic [31:0]      data_d;
	logic [CTL_W-1:0] tail;

	assign tail = ctl.len - CTL_W'(1);

	always_comb begin
		data_d = data_q;
		unique case (ctl.op)
			CELL_HOLD: data_d = data_q;
			CELL_INS: begin
				if (J == ctl.idx) begin
					data_d = value_in;
				end else if (J > ctl.idx) begin
					data_d = left_in;
				end
			end
			CELL_DEL: begin
				if (J >= ctl.idx) begin
					data_d = right_in;
				end
			end
			CELL_ROT: begin
				if (J == tail) begin
					data_d = head_in;
				end else if (J < tail) begin
					data_d = right_in;
				end
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

/* hdl/positional_ordered_list.sv */
// ----------------------------------------------------------------------------
// positional_ordered_list: bounded ordered list in a row of cells
// Inserts, deletes and dumps signed 32-bit elements by position.
// ----------------------------------------------------------------------------
// A command enters on the s group: s_tuser carries the command code, s_tdata
// the value and the 1-based position. Results leave on the m group: m_tuser
// carries the status, m_tdata the element value and the count, m_tlast marks
// the final result of a command.
// Inserts and deletes shift the cells from the position on in parallel, so
// their single status result is in the output register in the cycle after the
// transfer. A dump of n elements rotates the occupied cells through the
// head, one element per cycle while the receiver does not stall, and yields n
// results; no new command is taken until the last of them is loaded. Without
// stalls the block takes one command per cycle outside a dump.
// When the receiver stalls, the output register holds its result and the
// cells and the dump counter wait with it.
// Reset empties the list; cell contents are left as they are and are never
// read before they are written.
// ----------------------------------------------------------------------------
module positional_ordered_list #(
	parameter int CAPACITY = pol_pkg::POL_CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // value[31:0], position[37:32], zero[39:38]
	input  logic [2:0]  s_tuser,  // cmd[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // value_res[31:0], count[37:32], zero[39:38]
	output logic [1:0]  m_tuser,  // status[1:0]
	output logic        m_tlast
);
	import pol_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	state_t         state_q, state_d;
	logic [CW-1:0]  len_q, len_d;
	logic [CW-1:0]  cnt_q, cnt_d;
	logic           ov_q;
	logic [31:0]    oval_q, oval_d;
	logic [1:0]     ost_q, ost_d;
	logic           olast_q, olast_d;
	logic [5:0]     ocnt_q;
	logic           load;
	logic           free;
	logic [7:0]     pos_w;
	logic [7:0]     len_w;
	logic [7:0]     ins_pos;
	logic [7:0]     del_pos;
	cell_ctl_t      ctl;
	logic [31:0]    cell_data [CAPACITY];

	assign free  = !ov_q || m_tready;
	assign len_w = 8'(len_q);
	assign pos_w = {2'b00, s_tdata[37:32]};

	always_comb begin
		state_d  = state_q;
		len_d    = len_q;
		cnt_d    = cnt_q;
		load     = 1'b0;
		oval_d   = 32'd0;
		ost_d    = STS_OK;
		olast_d  = 1'b1;
		ctl.op   = CELL_HOLD;
		ctl.idx  = '0;
		ctl.len  = CTL_W'(len_q);
		s_tready = 1'b0;
		ins_pos  = pos_w;
		del_pos  = pos_w;
		unique case (state_q)
			S_IDLE: begin
				s_tready = free;
				if (s_tvalid && free) begin
					load = 1'b1;
					unique case (s_tuser)
						CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
							if (s_tuser == CMD_INS_FRONT) begin
								ins_pos = 8'd1;
							end else if (s_tuser == CMD_INS_BACK) begin
								ins_pos = len_w + 8'd1;
							end
							if (ins_pos < 8'd1 || ins_pos > len_w + 8'd1) begin
								ost_d = STS_NOPOS;
							end else if (len_w >= 8'(CAPACITY)) begin
								ost_d = STS_FULL;
							end else begin
								ctl.op  = CELL_INS;
								ctl.idx = CTL_W'(ins_pos - 8'd1);
								len_d   = len_q + CW'(1);
							end
						end
						CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT: begin
							if (s_tuser == CMD_DEL_FRONT) begin
								del_pos = 8'd1;
							end else if (s_tuser == CMD_DEL_BACK) begin
								del_pos = len_w;
							end
							if (len_q == '0) begin
								ost_d = STS_EMPTY;
							end else if (del_pos < 8'd1 || del_pos > len_w) begin
								ost_d = STS_NOPOS;
							end else begin
								ctl.op  = CELL_DEL;
								ctl.idx = CTL_W'(del_pos - 8'd1);
								len_d   = len_q - CW'(1);
							end
						end
						CMD_DUMP: begin
							if (len_q == '0) begin
								ost_d = STS_EMPTY;
							end else begin
								ctl.op  = CELL_ROT;
								oval_d  = cell_data[0];
								olast_d = (len_q == CW'(1));
								cnt_d   = CW'(1);
								if (len_q != CW'(1)) begin
									state_d = S_DUMP;
								end
							end
						end
						default: ost_d = STS_OK;
					endcase
				end
			end
			S_DUMP: begin
				if (free) begin
					load    = 1'b1;
					ctl.op  = CELL_ROT;
					oval_d  = cell_data[0];
					olast_d = (cnt_q + CW'(1) == len_q);
					cnt_d   = cnt_q + CW'(1);
					if (olast_d) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			if (load) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			oval_q  <= oval_d;
			ost_q   <= ost_d;
			olast_q <= olast_d;
			ocnt_q  <= 6'(len_d);
		end
	end

	for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
		pol_cell #(
			.INDEX(j)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.value_in (s_tdata[31:0]),
			.left_in  ((j == 0) ? 32'd0 : cell_data[(j == 0) ? 0 : j - 1]),
			.right_in (cell_data[(j == CAPACITY - 1) ? j : j + 1]),
			.head_in  (cell_data[0]),
			.data     (cell_data[j])
		);
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {2'b00, ocnt_q, oval_q};
	assign m_tuser  = ost_q;
	assign m_tlast  = olast_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= CW'(CAPACITY))
		else $error("element count exceeds capacity");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != STS_OK |-> m_tlast)
		else $error("error status without last flag");

	a_dump_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DUMP |=> $stable(len_q))
		else $error("count changed during a dump");

	a_dump_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == CMD_DUMP && len_q != '0
		|=> m_tvalid && m_tuser == STS_OK)
		else $error("dump transfer did not yield an element");

endmodule
